// ===== rtl/bss_pkg.sv =====
`timescale 1ns / 1ps

package bss_pkg;

  // geometry of the device and the request
  localparam int SECTOR_BYTES      = 512;
  localparam int MAX_REQUEST_BYTES = 16384;

  localparam int ADDR_W   = 32;
  localparam int COUNT_W  = 15;
  localparam int OFF_W    = $clog2(SECTOR_BYTES);
  localparam int LEN_W    = OFF_W + 1;
  localparam int SECTOR_W = ADDR_W - OFF_W;
  localparam int STATUS_W = 3;

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRESENT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LBA      = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_RANGE  = 3'd1,
    ST_ABSENT = 3'd2,
    ST_NOLBA  = 3'd3,
    ST_EMPTY  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SPLIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit_status;
    logic emit_chunk;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic err;
    logic chunk_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/bss_if.sv =====
`timescale 1ns / 1ps

interface bss_req_if;
  import bss_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [ADDR_W-1:0]  byte_address;
  logic [COUNT_W-1:0] byte_count;

  modport source (output valid, output op, output byte_address, output byte_count,
                  input ready);
  modport sink (input valid, input op, input byte_address, input byte_count,
                output ready);
endinterface

interface bss_desc_if;
  import bss_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SECTOR_W-1:0] sector_number;
  logic [OFF_W-1:0]    sector_offset;
  logic [LEN_W-1:0]    chunk_length;
  logic [COUNT_W-1:0]  buffer_offset;
  logic                needs_readback;
  logic                is_last;

  modport source (output valid, output status, output sector_number, output sector_offset,
                  output chunk_length, output buffer_offset, output needs_readback,
                  output is_last, input ready);
  modport sink (input valid, input status, input sector_number, input sector_offset,
                input chunk_length, input buffer_offset, input needs_readback,
                input is_last, output ready);
endinterface

// ===== rtl/byte_range_sector_splitter.sv =====
`timescale 1ns / 1ps

// Splits a read or write request (byte address, byte count) into one
// descriptor per 512-byte sector spanned, with sector number, offset and
// length in the sector, running buffer offset, a read-back flag for partial
// write chunks and a last marker. A request past capacity or over 16384
// bytes, to an absent drive or without LBA support, or an empty one, yields
// a single status result. Timing: a request is taken only in the idle state;
// a range check state follows, then the single chunk datapath puts out one
// descriptor per cycle while the output register is free. A new request is
// not taken until the previous one has issued its last descriptor or its
// status result.
// The next request is taken while the final descriptor still waits in the
// output register. Configuration is written over the APB-style port at byte
// addresses 0 (capacity), 4 (device present) and 8 (LBA supported).

module byte_range_sector_splitter import bss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bss_req_if.sink               req,
  bss_desc_if.source            desc,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [ADDR_W-1:0] capacity;
  logic              present;
  logic              lba;
  ctrl_cmd_t         cmd;
  dp_stat_t          stat;

  assign pready = 1'b1;

  // configuration registers
  bss_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .capacity_o (capacity),
    .present_o  (present),
    .lba_o      (lba)
  );

  // sequencing
  bss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // address walk and output register
  bss_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .op_i             (req.op),
    .byte_address_i   (req.byte_address),
    .byte_count_i     (req.byte_count),
    .capacity_i       (capacity),
    .present_i        (present),
    .lba_i            (lba),
    .out_ready_i      (desc.ready),
    .out_valid_o      (desc.valid),
    .status_o         (desc.status),
    .sector_number_o  (desc.sector_number),
    .sector_offset_o  (desc.sector_offset),
    .chunk_length_o   (desc.chunk_length),
    .buffer_offset_o  (desc.buffer_offset),
    .needs_readback_o (desc.needs_readback),
    .is_last_o        (desc.is_last)
  );

endmodule

// ===== rtl/bss_regs.sv =====
`timescale 1ns / 1ps

module bss_regs import bss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic [ADDR_W-1:0]     capacity_o,
  output logic                  present_o,
  output logic                  lba_o
);

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;
  logic [ADDR_W-1:0]    capacity_q;
  logic                 present_q;
  logic                 lba_q;

  assign idx   = paddr[CFG_ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= '0;
      present_q  <= 1'b0;
      lba_q      <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_CAPACITY: capacity_q <= pwdata[ADDR_W-1:0];
        REG_PRESENT:  present_q  <= pwdata[0];
        REG_LBA:      lba_q      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_CAPACITY: prdata = CFG_DATA_W'(capacity_q);
      REG_PRESENT:  prdata = CFG_DATA_W'(present_q);
      REG_LBA:      prdata = CFG_DATA_W'(lba_q);
      default:      prdata = '0;
    endcase
  end

  assign capacity_o = capacity_q;
  assign present_o  = present_q;
  assign lba_o      = lba_q;

endmodule

// ===== rtl/bss_dp.sv =====
`timescale 1ns / 1ps

module bss_dp import bss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output dp_stat_t            stat_o,
  input  logic                op_i,
  input  logic [ADDR_W-1:0]   byte_address_i,
  input  logic [COUNT_W-1:0]  byte_count_i,
  input  logic [ADDR_W-1:0]   capacity_i,
  input  logic                present_i,
  input  logic                lba_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [SECTOR_W-1:0] sector_number_o,
  output logic [OFF_W-1:0]    sector_offset_o,
  output logic [LEN_W-1:0]    chunk_length_o,
  output logic [COUNT_W-1:0]  buffer_offset_o,
  output logic                needs_readback_o,
  output logic                is_last_o
);

  // walking position within the request
  logic [SECTOR_W-1:0] cur_sector_q;
  logic [OFF_W-1:0]    cur_off_q;
  logic [COUNT_W-1:0]  remaining_q;
  logic [COUNT_W-1:0]  boff_q;
  logic                is_write_q;

  // output register
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [SECTOR_W-1:0] sector_q;
  logic [OFF_W-1:0]    soff_q;
  logic [LEN_W-1:0]    len_q;
  logic [COUNT_W-1:0]  obuf_q;
  logic                rb_q;
  logic                last_q;

  logic [ADDR_W:0]     end_w;
  status_e             chk_status;
  logic [LEN_W-1:0]    room;
  logic                chunk_last;
  logic [LEN_W-1:0]    chunk_len;

  // request check, 33-bit end address so nothing wraps
  assign end_w = {1'b0, cur_sector_q, cur_off_q} + (ADDR_W + 1)'(remaining_q);

  always_comb begin
    if (remaining_q > COUNT_W'(MAX_REQUEST_BYTES) || end_w > {1'b0, capacity_i}) begin
      chk_status = ST_RANGE;
    end else if (!present_i) begin
      chk_status = ST_ABSENT;
    end else if (!lba_i) begin
      chk_status = ST_NOLBA;
    end else if (remaining_q == '0) begin
      chk_status = ST_EMPTY;
    end else begin
      chk_status = ST_OK;
    end
  end

  // current chunk: rest of the sector or rest of the request
  assign room       = LEN_W'(SECTOR_BYTES) - {1'b0, cur_off_q};
  assign chunk_last = remaining_q <= COUNT_W'(room);
  assign chunk_len  = chunk_last ? remaining_q[LEN_W-1:0] : room;

  assign stat_o.err        = chk_status != ST_OK;
  assign stat_o.chunk_last = chunk_last;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // position registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_sector_q <= byte_address_i[ADDR_W-1:OFF_W];
      cur_off_q    <= byte_address_i[OFF_W-1:0];
      remaining_q  <= byte_count_i;
      boff_q       <= '0;
      is_write_q   <= op_i;
    end else if (cmd_i.emit_chunk) begin
      cur_sector_q <= cur_sector_q + SECTOR_W'(1);
      cur_off_q    <= '0;
      remaining_q  <= remaining_q - COUNT_W'(chunk_len);
      boff_q       <= boff_q + COUNT_W'(chunk_len);
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_status || cmd_i.emit_chunk) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_status) begin
      status_q <= chk_status;
      sector_q <= '0;
      soff_q   <= '0;
      len_q    <= '0;
      obuf_q   <= '0;
      rb_q     <= 1'b0;
      last_q   <= 1'b1;
    end else if (cmd_i.emit_chunk) begin
      status_q <= ST_OK;
      sector_q <= cur_sector_q;
      soff_q   <= cur_off_q;
      len_q    <= chunk_len;
      obuf_q   <= boff_q;
      rb_q     <= is_write_q && (chunk_len < LEN_W'(SECTOR_BYTES));
      last_q   <= chunk_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign sector_number_o  = sector_q;
  assign sector_offset_o  = soff_q;
  assign chunk_length_o   = len_q;
  assign buffer_offset_o  = obuf_q;
  assign needs_readback_o = rb_q;
  assign is_last_o        = last_q;

  // a data descriptor never has zero length and never exceeds a sector
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == ST_OK |->
      len_q != '0 && len_q <= LEN_W'(SECTOR_BYTES))
    else $error("chunk length out of range");

  // a status result always closes the request
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != ST_OK |-> last_q)
    else $error("status result without last marker");

  // chunk never reaches past the end of its sector
  a_in_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_chunk |=>
      (LEN_W + 1)'(soff_q) + (LEN_W + 1)'(len_q) <= (LEN_W + 1)'(SECTOR_BYTES))
    else $error("chunk crosses sector boundary");

endmodule

// ===== rtl/bss_ctrl.sv =====
`timescale 1ns / 1ps

module bss_ctrl import bss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!stat_i.err) begin
          state_d = S_SPLIT;
        end else if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_SPLIT: begin
        if (stat_i.out_free && stat_i.chunk_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready_o       = 1'b0;
    cmd_o.load        = 1'b0;
    cmd_o.emit_status = 1'b0;
    cmd_o.emit_chunk  = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      S_CHECK: begin
        cmd_o.emit_status = stat_i.err && stat_i.out_free;
      end
      S_SPLIT: begin
        cmd_o.emit_chunk = stat_i.out_free;
      end
      default: ;
    endcase
  end

  // only one result source per cycle
  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.emit_status && cmd_o.emit_chunk))
    else $error("status and chunk emitted together");

  // never overwrite an untaken result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_status || cmd_o.emit_chunk) |-> stat_i.out_free)
    else $error("emit while output register busy");

  // a load starts the check of the new request; loads come only from idle
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_CHECK)
    else $error("load did not start a check");

endmodule

// ===== sim/sector_split_checker.sv =====
`timescale 1ns / 1ps

module sector_split_checker import bss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bss_req_if                    req,
  bss_desc_if                   desc,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    mismatch_count,
  output int                    outstanding,
  output int                    requests_seen,
  output int                    chunks_seen,
  output int                    status_seen
);

  typedef struct packed {
    status_e             status;
    logic [SECTOR_W-1:0] sector;
    logic [OFF_W-1:0]    soff;
    logic [LEN_W-1:0]    len;
    logic [COUNT_W-1:0]  boff;
    logic                readback;
    logic                last;
  } desc_t;

  // shadow copy of the configuration registers
  logic [ADDR_W-1:0] capacity_q;
  logic              present_q;
  logic              lba_q;

  desc_t expected_descs[$];

  // expected descriptors of one request, pushed in output order
  function automatic void split_request(input logic is_write, input logic [ADDR_W-1:0] addr,
                                        input logic [COUNT_W-1:0] count);
    logic [ADDR_W:0]     end_addr;
    logic [ADDR_W-1:0]   last_byte;
    logic [SECTOR_W-1:0] first_sec;
    logic [SECTOR_W-1:0] last_sec;
    logic [SECTOR_W-1:0] sec;
    logic [LEN_W-1:0]    chunk_end;
    logic [COUNT_W-1:0]  covered;
    desc_t               d;
    end_addr = {1'b0, addr} + (ADDR_W+1)'(count);
    d = '0;
    d.last = 1'b1;
    if (count > COUNT_W'(MAX_REQUEST_BYTES) || end_addr > {1'b0, capacity_q}) begin
      d.status = ST_RANGE;
    end else if (!present_q) begin
      d.status = ST_ABSENT;
    end else if (!lba_q) begin
      d.status = ST_NOLBA;
    end else if (count == '0) begin
      d.status = ST_EMPTY;
    end else begin
      last_byte = addr + ADDR_W'(count) - 1'b1;
      first_sec = addr[ADDR_W-1:OFF_W];
      last_sec  = last_byte[ADDR_W-1:OFF_W];
      sec       = first_sec;
      covered   = '0;
      do begin
        d.status   = ST_OK;
        d.sector   = sec;
        d.soff     = (sec == first_sec) ? addr[OFF_W-1:0] : '0;
        chunk_end  = (sec == last_sec) ? LEN_W'(last_byte[OFF_W-1:0]) + 1'b1
                                       : LEN_W'(SECTOR_BYTES);
        d.len      = chunk_end - LEN_W'(d.soff);
        d.boff     = covered;
        d.readback = is_write && (d.len < LEN_W'(SECTOR_BYTES));
        d.last     = (sec == last_sec);
        expected_descs.push_back(d);
        covered    = covered + COUNT_W'(d.len);
        sec        = sec + 1'b1;
      end while (!d.last);
      return;
    end
    expected_descs.push_back(d);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("descriptor field %s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // watch config writes, descriptors and requests on every edge
  always @(posedge clk_i or negedge rst_ni) begin
    desc_t want;
    if (!rst_ni) begin
      capacity_q = '0;
      present_q  = 1'b0;
      lba_q      = 1'b0;
      expected_descs.delete();
      mismatch_count = 0;
      requests_seen  = 0;
      chunks_seen    = 0;
      status_seen    = 0;
      outstanding   <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:2])
          REG_CAPACITY: capacity_q = pwdata[ADDR_W-1:0];
          REG_PRESENT:  present_q  = pwdata[0];
          REG_LBA:      lba_q      = pwdata[0];
          default: ;
        endcase
      end

      // compare the descriptor transaction with the oldest expectation
      if (desc.valid && desc.ready) begin
        if (expected_descs.size() == 0) begin
          $error("unexpected descriptor: status %0d sector 0x%0h len %0d", desc.status,
                 desc.sector_number, desc.chunk_length);
          mismatch_count++;
        end else begin
          want = expected_descs.pop_front();
          check_field("status", want.status, desc.status);
          check_field("sector_number", want.sector, desc.sector_number);
          check_field("sector_offset", want.soff, desc.sector_offset);
          check_field("chunk_length", want.len, desc.chunk_length);
          check_field("buffer_offset", want.boff, desc.buffer_offset);
          check_field("needs_readback", want.readback, desc.needs_readback);
          check_field("is_last", want.last, desc.is_last);
          if (want.status == ST_OK) chunks_seen++;
          else status_seen++;
        end
      end

      if (req.valid && req.ready) begin
        split_request(req.op, req.byte_address, req.byte_count);
        requests_seen++;
      end

      outstanding <= expected_descs.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bss_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // index with no register behind it
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatch_count;
  int outstanding;
  int requests_seen;
  int chunks_seen;
  int status_seen;
  int cycle_count;

  logic              steady;
  logic              hold_output;
  logic [ADDR_W-1:0] capacity_cfg;

  bss_req_if  req_bus ();
  bss_desc_if desc_bus ();

  always #5 clk_i = ~clk_i;

  byte_range_sector_splitter u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_bus),
    .desc    (desc_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sector_split_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req            (req_bus),
    .desc           (desc_bus),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .requests_seen  (requests_seen),
    .chunks_seen    (chunks_seen),
    .status_seen    (status_seen)
  );

  // register write: setup cycle, then access cycle
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_CAPACITY) capacity_cfg = value;
  endtask

  task automatic configure(input logic [31:0] cap, input logic present, input logic lba);
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_PRESENT, {31'd0, present});
    write_reg(REG_LBA, {31'd0, lba});
  endtask

  // offer one request, with an occasional gap, until the block takes it
  task automatic send_req(input logic op, input logic [ADDR_W-1:0] addr,
                          input logic [COUNT_W-1:0] count);
    if (!steady && $urandom_range(99) < 10) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.op           <= op;
    req_bus.byte_address <= addr;
    req_bus.byte_count   <= count;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  // stop offering and wait until every descriptor is out
  task automatic drain();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // mostly in-range requests of modest size, some oversize, empty and stray ones
  task automatic random_request();
    int unsigned        pick;
    logic [COUNT_W-1:0] count;
    logic [ADDR_W-1:0]  addr;
    pick = $urandom_range(99);
    if (pick < 60) count = COUNT_W'($urandom_range(1200, 1));
    else if (pick < 75) count = COUNT_W'($urandom_range(MAX_REQUEST_BYTES - 1, 1201));
    else if (pick < 80) count = COUNT_W'(MAX_REQUEST_BYTES);
    else if (pick < 85) count = '0;
    else if (pick < 90) count = COUNT_W'($urandom_range(32767, MAX_REQUEST_BYTES + 1));
    else count = COUNT_W'($urandom_range(600, 1));
    addr = $urandom;
    if ($urandom_range(99) < 80 && capacity_cfg >= ADDR_W'(count)) begin
      addr = $urandom_range(capacity_cfg - ADDR_W'(count), 0);
      case ($urandom_range(3))
        0: addr[OFF_W-1:0] = '0;
        1: addr[OFF_W-1:0] = '1;
        default: ;
      endcase
    end
    send_req(logic'($urandom_range(1)), addr, count);
  endtask

  // descriptor sink: random stalls, one long hold on request
  initial begin
    desc_bus.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_output) begin
        hold_output = 1'b0;
        desc_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        desc_bus.ready <= steady || ($urandom_range(99) >= 10);
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $error("run did not finish within %0d cycles", CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    req_bus.valid        = 1'b0;
    req_bus.op           = OP_READ;
    req_bus.byte_address = '0;
    req_bus.byte_count   = '0;
    steady               = 1'b0;
    hold_output          = 1'b0;
    capacity_cfg         = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: zero capacity, no drive, no lba
    send_req(OP_READ, '0, '0);
    send_req(OP_READ, '0, 15'd1);
    send_req(OP_WRITE, 32'hFFFF_FFFF, 15'h7FFF);
    drain();

    // drive present with upper bits set, lba bit clear, stray write to the unused index
    write_reg(REG_CAPACITY, 32'hFFFF_FFFF);
    write_reg(REG_PRESENT, 32'hFFFF_FFFF);
    write_reg(REG_LBA, 32'hFFFF_FFFE);
    write_reg(REG_UNUSED, 32'h0000_0000);
    send_req(OP_READ, 32'h0000_1000, 15'd10);
    send_req(OP_WRITE, 32'h0000_0000, 15'd16385);
    drain();
    write_reg(REG_LBA, 32'h0000_0001);

    // splitting corners on a full-size device
    send_req(OP_READ, '0, '0);
    send_req(OP_READ, '0, 15'd1);
    send_req(OP_WRITE, '0, 15'd512);
    send_req(OP_WRITE, 32'd1, 15'd511);
    send_req(OP_WRITE, 32'd511, 15'd2);
    send_req(OP_READ, 32'd100, 15'd16384);
    send_req(OP_WRITE, 32'd512, 15'd16384);
    send_req(OP_WRITE, 32'h0000_01FF, 15'd16384);
    send_req(OP_READ, '0, 15'd16385);
    send_req(OP_WRITE, 32'hFFFF_FFFF, '0);
    send_req(OP_READ, 32'hFFFF_FFFF, 15'd1);
    send_req(OP_WRITE, 32'hFFFF_FFFE, 15'd1);
    send_req(OP_WRITE, 32'hFFFF_FE00, 15'd512);
    send_req(OP_READ, 32'hFFFF_C000, 15'd16384);
    drain();

    // small device: edge of capacity, then drive gone
    write_reg(REG_CAPACITY, 32'h0000_1000);
    send_req(OP_WRITE, 32'h0000_0F00, 15'h100);
    send_req(OP_READ, 32'h0000_0F00, 15'h101);
    send_req(OP_READ, 32'h0000_1000, '0);
    drain();
    write_reg(REG_PRESENT, 32'h0000_0000);
    send_req(OP_READ, 32'h0000_0010, 15'd20);
    drain();

    // long output hold while requests keep coming
    configure(32'hFFFF_FFFF, 1'b1, 1'b1);
    hold_output = 1'b1;
    repeat (40) random_request();
    drain();

    // random phases over several settings
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          steady = 1'b1;
          configure(32'hFFFF_FFFF, 1'b1, 1'b1);
          repeat (60) random_request();
        end
        1: begin
          steady = 1'b0;
          repeat (60) random_request();
        end
        2: begin
          configure($urandom_range(32'h0010_0000, 1), 1'b1, 1'b1);
          repeat (40) random_request();
        end
        3: begin
          configure($urandom, logic'($urandom_range(1)), logic'($urandom_range(1)));
          repeat (30) random_request();
        end
        4: begin
          configure(32'h0000_0000, 1'b1, 1'b1);
          repeat (10) random_request();
        end
        default: begin
          configure(32'hFFFF_FFFF, 1'b1, 1'b1);
          repeat (40) random_request();
        end
      endcase
      drain();
    end

    repeat (50) @(posedge clk_i);

    $display("run covered %0d requests: %0d sector descriptors, %0d status results",
             requests_seen, chunks_seen, status_seen);
    $display("settings: reset, full/small/zero/random capacity, drive absent, no lba, "
             , "long output hold");
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
